### rtl/core/poly_decryptor_byte_interpreter_defines.svh
// Assertion macros shared by the decryptor interpreter RTL.
// Each use stands on a line of its own and takes no trailing semicolon.
`ifndef POLY_DECRYPTOR_BYTE_INTERPRETER_DEFINES_SVH
`define POLY_DECRYPTOR_BYTE_INTERPRETER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PDBI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdbi: same-cycle check failed");
// next-cycle implication
`define PDBI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdbi: next-cycle check failed");
`else
`define PDBI_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define PDBI_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/pdbi_pkg.sv
`default_nettype none
package pdbi_pkg;

    // Opcodes
    localparam logic [7:0] OP_JMP    = 8'hEB;
    localparam logic [7:0] OP_DEC    = 8'hFE;
    localparam logic [7:0] OP_SUB_CL = 8'h2A;
    localparam logic [7:0] OP_ADD_CL = 8'h02;
    localparam logic [7:0] OP_XOR_CL = 8'h32;
    localparam logic [7:0] OP_ADD_I  = 8'h04;
    localparam logic [7:0] OP_XOR_I  = 8'h34;
    localparam logic [7:0] OP_SUB_I  = 8'h2C;
    localparam logic [7:0] OP_ROT_I  = 8'hC0;
    localparam logic [7:0] OP_ROT_CL = 8'hD2;

    // One-byte no-op codes
    localparam logic [7:0] OP_NOP    = 8'h90;
    localparam logic [7:0] OP_CLC    = 8'hF8;
    localparam logic [7:0] OP_STC    = 8'hF9;
    localparam logic [7:0] OP_JMPN   = 8'hE9;
    localparam logic [7:0] OP_CALL   = 8'hE8;
    localparam logic [7:0] OP_LODS   = 8'hAC;

    // Rotate mode bytes
    localparam logic [7:0] MODE_ROL  = 8'hC0;
    localparam logic [7:0] MODE_ROR  = 8'hC8;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_OP   = 2'd1;
    localparam logic [1:0] ST_PAST_END = 2'd2;

    // Request kinds
    localparam logic REQ_PROG = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // Register word indexes and APB address width
    localparam int   APB_AW          = 3;
    localparam logic REG_PROG_LEN    = 1'b0;
    localparam logic REG_START_COUNT = 1'b1;

    // Sequencer states
    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] S_OP   = 3'd1;
    localparam logic [STATE_W-1:0] S_ARG  = 3'd2;
    localparam logic [STATE_W-1:0] S_ARG2 = 3'd3;
    localparam logic [STATE_W-1:0] S_DONE = 3'd4;

    // Control result of one interpreter step
    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [1:0]         err;
    } step_t;

    function automatic logic [7:0] rol8(input logic [7:0] v, input logic [2:0] s);
        logic [15:0] d;
        d = {v, v} << s;
        return d[15:8];
    endfunction

    function automatic logic [7:0] ror8(input logic [7:0] v, input logic [2:0] s);
        logic [15:0] d;
        d = {v, v} >> s;
        return d[7:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/poly_decryptor_byte_interpreter.sv
`default_nettype none
`include "poly_decryptor_byte_interpreter_defines.svh"
// Port group  Dir  Handshake              Contents
// s_*         in   s_tvalid / s_tready    s_tuser req_type; s_tdata program write or data byte
// m_*         out  m_tvalid / m_tready    m_tdata plain_byte, status
// APB         in   psel/penable/pwrite    program_length at 0x0, start_count at 0x4
//
// A data byte is run by fetching program bytes one by one (opcodes and
// operands; skipped bytes are not read): the single read port of the program
// store gives one byte a cycle. Reset clears control and registers only; the
// program store holds nothing until written. The next item is taken while a
// result waits in m_tdata; a finished run waits in its done state until the
// result register is free.
module poly_decryptor_byte_interpreter #(
    parameter int PROG_DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // prog_addr, prog_byte, data_byte
    input  logic [0:0]                  s_tuser,   // req_type
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // plain_byte, status, zero pad
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdbi_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pdbi_pkg::*;

    localparam int AW = $clog2(PROG_DEPTH);
    localparam int PW = $clog2(PROG_DEPTH + 258);

    logic [STATE_W-1:0] state_reg, state_next;
    logic [PW-1:0]      ptr_reg, ptr_next;
    logic [PW-1:0]      run_len_reg, run_len_next;
    logic [7:0]         val_reg, val_next;
    logic [7:0]         op_reg, op_next;
    logic [7:0]         mode_reg, mode_next;
    logic [1:0]         run_err_reg, run_err_next;
    logic [8:0]         program_length_reg;
    logic [7:0]         start_count_reg;
    logic [7:0]         running_count_reg;
    logic [1:0]         error_code_reg;
    logic               m_tvalid_reg;
    logic [7:0]         plain_reg;
    logic [1:0]         status_reg;

    logic               s_fire;
    logic               cfg_wr;
    logic               start_wr;
    logic               out_load;
    logic [1:0]         err_final;
    logic [PW-1:0]      len_w;
    logic               addr_ok;
    logic               wr_en;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         rd_data;
    step_t              ctl;
    logic [PW-1:0]      ptr_step;
    logic [7:0]         val_step;

    // handshakes
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign start_wr = cfg_wr && (paddr[2] == REG_START_COUNT);
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // length clamped to the store depth
    assign len_w = (PW'(program_length_reg) > PW'(PROG_DEPTH)) ? PW'(PROG_DEPTH)
                                                               : PW'(program_length_reg);
    assign addr_ok = (32'(s_tdata[7:0]) < PROG_DEPTH);
    assign wr_en   = s_fire && (s_tuser[0] == REQ_PROG) && addr_ok;

    // first error of a run sticks
    assign err_final = (error_code_reg == ST_OK) ? run_err_reg : error_code_reg;

    pdbi_ram #(
        .WIDTH (8),
        .DEPTH (PROG_DEPTH)
    ) u_prog_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_tdata[7:0])),
        .wr_data (s_tdata[15:8]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pdbi_step #(
        .PW (PW)
    ) u_step (
        .state    (state_reg),
        .ptr      (ptr_reg),
        .len      (run_len_reg),
        .op       (op_reg),
        .mode     (mode_reg),
        .rd_data  (rd_data),
        .val      (val_reg),
        .cnt      (running_count_reg),
        .ctl      (ctl),
        .ptr_step (ptr_step),
        .val_step (val_step)
    );

    // sequencer: one program byte read per cycle
    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        run_len_next = run_len_reg;
        val_next     = val_reg;
        op_next      = op_reg;
        mode_next    = mode_reg;
        run_err_next = run_err_reg;
        rd_en        = 1'b0;
        rd_addr      = ptr_step[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire && (s_tuser[0] == REQ_DATA))
                begin
                    val_next     = s_tdata[23:16];
                    ptr_next     = '0;
                    run_len_next = len_w;
                    run_err_next = ST_OK;
                    if (len_w == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_OP;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                    end
                end
            end
            S_OP, S_ARG, S_ARG2:
            begin
                state_next   = ctl.state;
                ptr_next     = ptr_step;
                val_next     = val_step;
                run_err_next = ctl.err;
                rd_en        = (ctl.state != S_DONE);
                if (state_reg == S_OP)
                begin
                    op_next = rd_data;
                end
                if (state_reg == S_ARG)
                begin
                    mode_next = rd_data;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            program_length_reg <= '0;
            start_count_reg    <= '0;
            running_count_reg  <= '0;
            error_code_reg     <= ST_OK;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && (paddr[2] == REG_PROG_LEN))
            begin
                program_length_reg <= pwdata[8:0];
            end
            if (start_wr)
            begin
                start_count_reg   <= pwdata[7:0];
                running_count_reg <= pwdata[7:0];
                error_code_reg    <= ST_OK;
            end
            else if (out_load)
            begin
                running_count_reg <= running_count_reg - 8'd1;
                error_code_reg    <= err_final;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        run_len_reg <= run_len_next;
        val_reg     <= val_next;
        op_reg      <= op_next;
        mode_reg    <= mode_next;
        run_err_reg <= run_err_next;
        if (out_load)
        begin
            plain_reg  <= val_reg;
            status_reg <= err_final;
        end
    end

    // outputs
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, status_reg, plain_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_START_COUNT) ? {24'b0, start_count_reg}
                                                    : {23'b0, program_length_reg};

    // checks
    `PDBI_ASSERT_IMPL(a_ptr_in_program, clk, rst_n, (state_reg == S_OP || state_reg == S_ARG || state_reg == S_ARG2), ptr_reg < run_len_reg)
    `PDBI_ASSERT_IMPL(a_result_from_done, clk, rst_n, $rose(m_tvalid_reg), $past(state_reg) == S_DONE)
    `PDBI_ASSERT_IMPL(a_arg2_rotate_only, clk, rst_n, state_reg == S_ARG2, op_reg == OP_ROT_I || op_reg == OP_ROT_CL)
    `PDBI_ASSERT_NEXT(a_count_steps, clk, rst_n, out_load && !start_wr, running_count_reg == $past(running_count_reg) - 8'd1)
    `PDBI_ASSERT_NEXT(a_error_sticky, clk, rst_n, (error_code_reg != ST_OK) && !start_wr, error_code_reg == $past(error_code_reg))

endmodule
`default_nettype wire

### rtl/core/pdbi_ram.sv
`default_nettype none
module pdbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/core/pdbi_step.sv
`default_nettype none
module pdbi_step #(
    parameter int PW = 10
) (
    input  logic [pdbi_pkg::STATE_W-1:0] state,
    input  logic [PW-1:0]                ptr,
    input  logic [PW-1:0]                len,
    input  logic [7:0]                   op,
    input  logic [7:0]                   mode,
    input  logic [7:0]                   rd_data,
    input  logic [7:0]                   val,
    input  logic [7:0]                   cnt,
    output pdbi_pkg::step_t              ctl,
    output logic [PW-1:0]                ptr_step,
    output logic [7:0]                   val_step
);
    import pdbi_pkg::*;

    logic [PW-1:0] ptr1;
    logic [PW-1:0] ptr2;
    logic [PW-1:0] ptr_jmp;

    assign ptr1    = ptr + PW'(1);
    assign ptr2    = ptr + PW'(2);
    assign ptr_jmp = ptr + PW'(rd_data) + PW'(1);

    // rd_data holds the program byte at ptr; decode it against the current phase
    always_comb
    begin
        logic          adv;
        logic [PW-1:0] tgt;
        ctl.state = state;
        ctl.err   = ST_OK;
        ptr_step  = ptr;
        val_step  = val;
        adv       = 1'b0;
        tgt       = ptr1;
        case (state)
            S_OP:
            begin
                case (rd_data)
                    OP_JMP, OP_ADD_I, OP_XOR_I, OP_SUB_I, OP_ROT_I, OP_ROT_CL:
                    begin
                        if (ptr1 >= len)
                        begin
                            ctl.state = S_DONE;
                            ctl.err   = ST_PAST_END;
                        end
                        else
                        begin
                            ctl.state = S_ARG;
                            ptr_step  = ptr1;
                        end
                    end
                    // count forms skip the byte that follows
                    OP_DEC:
                    begin
                        val_step = val - 8'd1;
                        adv      = 1'b1;
                        tgt      = ptr2;
                    end
                    OP_SUB_CL:
                    begin
                        val_step = val - cnt;
                        adv      = 1'b1;
                        tgt      = ptr2;
                    end
                    OP_ADD_CL:
                    begin
                        val_step = val + cnt;
                        adv      = 1'b1;
                        tgt      = ptr2;
                    end
                    OP_XOR_CL:
                    begin
                        val_step = val ^ cnt;
                        adv      = 1'b1;
                        tgt      = ptr2;
                    end
                    OP_NOP, OP_CLC, OP_STC, OP_JMPN, OP_CALL, OP_LODS:
                    begin
                        adv = 1'b1;
                    end
                    default:
                    begin
                        ctl.state = S_DONE;
                        ctl.err   = ST_BAD_OP;
                    end
                endcase
            end
            S_ARG:
            begin
                case (op)
                    OP_JMP:
                    begin
                        adv = 1'b1;
                        tgt = ptr_jmp;
                    end
                    OP_ADD_I:
                    begin
                        val_step = val + rd_data;
                        adv      = 1'b1;
                    end
                    OP_XOR_I:
                    begin
                        val_step = val ^ rd_data;
                        adv      = 1'b1;
                    end
                    OP_SUB_I:
                    begin
                        val_step = val - rd_data;
                        adv      = 1'b1;
                    end
                    OP_ROT_I, OP_ROT_CL:
                    begin
                        if (ptr1 >= len)
                        begin
                            ctl.state = S_DONE;
                            ctl.err   = ST_PAST_END;
                        end
                        else
                        begin
                            ctl.state = S_ARG2;
                            ptr_step  = ptr1;
                        end
                    end
                    default:
                    begin
                        ctl.state = S_DONE;
                    end
                endcase
            end
            // third byte: immediate for C0, ignored for D2
            S_ARG2:
            begin
                adv = 1'b1;
                if (op == OP_ROT_I)
                begin
                    val_step = (mode == MODE_ROL) ? rol8(val, rd_data[2:0])
                                                  : ror8(val, rd_data[2:0]);
                end
                else
                begin
                    val_step = (mode == MODE_ROR) ? ror8(val, cnt[2:0])
                                                  : rol8(val, cnt[2:0]);
                end
            end
            default:
            begin
                ctl.state = state;
            end
        endcase
        // move on, or finish cleanly at the program end
        if (adv)
        begin
            ptr_step  = tgt;
            ctl.state = (tgt >= len) ? S_DONE : S_OP;
        end
    end

endmodule
`default_nettype wire

### sim/poly_decryptor_byte_interpreter_checker.sv
module poly_decryptor_byte_interpreter_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // prog_addr, prog_byte, data_byte
    input  logic [0:0]                  s_tuser,   // req_type
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [15:0]                 m_tdata,   // plain_byte, status, zero pad
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdbi_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          outstanding,
    output int                          mismatches,
    output int                          results_seen,
    output int                          flagged_results
);
    import pdbi_pkg::*;

    typedef struct packed {
        logic [7:0] plain;
        logic [1:0] status;
    } plain_item_t;

    // expected plain bytes, oldest first
    plain_item_t plain_q[$];

    // shadow of the block's program store, registers and run state
    logic [7:0] store_copy [0:255];
    logic [8:0] len_reg;
    logic [7:0] count_reg;
    logic [1:0] sticky;

    int          mism_n;
    int          results_n;
    int          flagged_n;
    plain_item_t want;
    plain_item_t next_plain;

    function automatic logic [7:0] rot_left(input logic [7:0] v, input logic [7:0] amt);
        logic [2:0] s;
        s = amt[2:0];
        if (s == 3'd0)
            return v;
        return (v << s) | (v >> (4'd8 - s));
    endfunction

    function automatic logic [7:0] rot_right(input logic [7:0] v, input logic [7:0] amt);
        logic [2:0] s;
        s = amt[2:0];
        if (s == 3'd0)
            return v;
        return (v >> s) | (v << (4'd8 - s));
    endfunction

    // walk the program once over one cipher byte
    function automatic plain_item_t run_decryptor(input logic [7:0] cipher);
        plain_item_t r;
        int unsigned lim;
        int unsigned pos;
        logic [7:0]  op;
        logic [7:0]  v;
        logic [7:0]  mode;
        logic [7:0]  arg;
        logic [1:0]  err;
        lim = (len_reg > 9'd256) ? 256 : len_reg;
        pos = 0;
        v = cipher;
        err = ST_OK;
        while (pos < lim && err == ST_OK)
        begin
            op = store_copy[pos];
            case (op)
                OP_JMP:
                begin
                    pos++;
                    if (pos >= lim)
                        err = ST_PAST_END;
                    else
                        pos += store_copy[pos];
                end
                OP_DEC:
                begin
                    v = v - 8'd1;
                    pos++;
                end
                OP_SUB_CL:
                begin
                    v = v - count_reg;
                    pos++;
                end
                OP_ADD_CL:
                begin
                    v = v + count_reg;
                    pos++;
                end
                OP_XOR_CL:
                begin
                    v = v ^ count_reg;
                    pos++;
                end
                OP_ADD_I, OP_XOR_I, OP_SUB_I:
                begin
                    pos++;
                    if (pos >= lim)
                        err = ST_PAST_END;
                    else
                    begin
                        arg = store_copy[pos];
                        if (op == OP_ADD_I)
                            v = v + arg;
                        else if (op == OP_XOR_I)
                            v = v ^ arg;
                        else
                            v = v - arg;
                    end
                end
                OP_ROT_I, OP_ROT_CL:
                begin
                    pos++;
                    if (pos >= lim)
                        err = ST_PAST_END;
                    else
                    begin
                        mode = store_copy[pos];
                        pos++;
                        if (pos >= lim)
                            err = ST_PAST_END;
                        else if (op == OP_ROT_I)
                            v = (mode == MODE_ROL) ? rot_left(v, store_copy[pos])
                                                   : rot_right(v, store_copy[pos]);
                        else
                            v = (mode == MODE_ROR) ? rot_right(v, count_reg)
                                                   : rot_left(v, count_reg);
                    end
                end
                OP_NOP, OP_CLC, OP_STC, OP_JMPN, OP_CALL, OP_LODS: ;
                default: err = ST_BAD_OP;
            endcase
            if (err == ST_OK)
                pos++;
        end
        r.plain = v;
        r.status = err;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mism_n++;
        if (mism_n <= 10)
            $display("mismatch: %s", msg);
    endtask

    // results are compared before new items are predicted at the same edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            len_reg = '0;
            count_reg = '0;
            sticky = ST_OK;
            plain_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_n++;
                if (m_tdata[9:8] != ST_OK)
                    flagged_n++;
                if (plain_q.size() == 0)
                    flag_mismatch($sformatf("result %04h with nothing expected", m_tdata));
                else
                begin
                    want = plain_q.pop_front();
                    if (m_tdata[7:0] != want.plain || m_tdata[9:8] != want.status ||
                        m_tdata[15:10] != 6'd0)
                        flag_mismatch($sformatf(
                            "expected plain %02h status %0d, got plain %02h status %0d pad %02h",
                            want.plain, want.status, m_tdata[7:0], m_tdata[9:8],
                            m_tdata[15:10]));
                end
            end

            // register writes; a start count write begins a new run
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_PROG_LEN, 2'b00})
                    len_reg = pwdata[8:0];
                else if (paddr == {REG_START_COUNT, 2'b00})
                begin
                    count_reg = pwdata[7:0];
                    sticky = ST_OK;
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == REQ_PROG)
                    store_copy[s_tdata[7:0]] = s_tdata[15:8];
                else
                begin
                    next_plain = run_decryptor(s_tdata[23:16]);
                    if (sticky == ST_OK)
                        sticky = next_plain.status;
                    next_plain.status = sticky;
                    plain_q.push_back(next_plain);
                    count_reg = count_reg - 8'd1;
                end
            end
        end
        outstanding <= plain_q.size();
        mismatches <= mism_n;
        results_seen <= results_n;
        flagged_results <= flagged_n;
    end

endmodule

### sim/poly_decryptor_byte_interpreter_test.sv
module poly_decryptor_byte_interpreter_test;
    import pdbi_pkg::*;

    localparam int         CYCLE_LIMIT   = 4000000;
    localparam int         RANDOM_ITEMS  = 1700;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         DRAIN_CYCLES  = 300;
    localparam int         MAX_GAP       = 64;
    localparam logic [7:0] BAD_OP_CODE   = 8'h00;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [23:0]                 s_tdata = '0;   // prog_addr, prog_byte, data_byte
    logic [0:0]                  s_tuser = '0;   // req_type
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [15:0]                 m_tdata;        // plain_byte, status, zero pad
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [APB_AW-1:0]           paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    int outstanding;
    int mismatches;
    int results_seen;
    int flagged_results;

    int send_idle_pct = 12;
    int recv_idle_pct = 81;
    int items_sent = 0;
    int prog_writes = 0;
    int data_sent = 0;
    int reg_writes = 0;
    int cycles = 0;

    // program image; slack at the top absorbs operands of a final instruction
    logic [7:0] prog_img [0:259];
    logic [7:0] nop_codes [0:5];

    poly_decryptor_byte_interpreter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    poly_decryptor_byte_interpreter_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .outstanding     (outstanding),
        .mismatches      (mismatches),
        .results_seen    (results_seen),
        .flagged_results (flagged_results)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("[poly_decryptor_byte_interpreter] ERROR");
            $finish;
        end
    end

    // one item, after a random number of idle cycles
    task automatic push_item(input logic kind, input logic [7:0] addr,
                             input logic [7:0] pbyte, input logic [7:0] dbyte);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {dbyte, pbyte, addr};
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (kind == REQ_DATA)
            data_sent++;
        else
            prog_writes++;
    endtask

    task automatic push_data(input logic [7:0] dbyte);
        push_item(REQ_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), dbyte);
    endtask

    // register write once the block has gone quiet
    task automatic write_reg(input logic idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes++;
    endtask

    // well-formed program of the given length; a broken one gets an unknown
    // opcode or a multi-byte instruction cut short at the end
    task automatic compose_program(input int len, input bit broken);
        int         p;
        int         kind;
        int         d;
        int         k;
        logic [7:0] b;
        bit         known;
        p = 0;
        while (p < len)
        begin
            kind = $urandom_range(0, 8);
            if (((kind == 5 || kind == 8) && len - p < 2) ||
                ((kind == 6 || kind == 7) && len - p < 3))
                kind = 0;
            case (kind)
                0:
                begin
                    prog_img[p] = nop_codes[$urandom_range(0, 5)];
                    p = p + 1;
                end
                1, 2, 3, 4:
                begin
                    case (kind)
                        1: prog_img[p] = OP_DEC;
                        2: prog_img[p] = OP_SUB_CL;
                        3: prog_img[p] = OP_ADD_CL;
                        default: prog_img[p] = OP_XOR_CL;
                    endcase
                    prog_img[p + 1] = 8'($urandom_range(0, 255));
                    p = p + 2;
                end
                5:
                begin
                    case ($urandom_range(0, 2))
                        0: prog_img[p] = OP_ADD_I;
                        1: prog_img[p] = OP_XOR_I;
                        default: prog_img[p] = OP_SUB_I;
                    endcase
                    prog_img[p + 1] = 8'($urandom_range(0, 255));
                    p = p + 2;
                end
                6:
                begin
                    prog_img[p] = OP_ROT_I;
                    prog_img[p + 1] = $urandom_range(0, 1) ? MODE_ROL
                                                           : 8'($urandom_range(0, 255));
                    prog_img[p + 2] = 8'($urandom_range(0, 255));
                    p = p + 3;
                end
                7:
                begin
                    prog_img[p] = OP_ROT_CL;
                    prog_img[p + 1] = $urandom_range(0, 1) ? MODE_ROR
                                                           : 8'($urandom_range(0, 255));
                    prog_img[p + 2] = 8'($urandom_range(0, 255));
                    p = p + 3;
                end
                default:
                begin
                    d = $urandom_range(0, 3);
                    prog_img[p] = OP_JMP;
                    prog_img[p + 1] = 8'(d);
                    for (k = 0; k < d; k++)
                        prog_img[p + 2 + k] = 8'($urandom_range(0, 255));
                    p = p + 2 + d;
                end
            endcase
        end
        if (broken && len > 0)
        begin
            if ($urandom_range(0, 1))
            begin
                do
                begin
                    b = 8'($urandom_range(0, 255));
                    case (b)
                        OP_JMP, OP_DEC, OP_SUB_CL, OP_ADD_CL, OP_XOR_CL, OP_ADD_I, OP_XOR_I,
                        OP_SUB_I, OP_ROT_I, OP_ROT_CL, OP_NOP, OP_CLC, OP_STC, OP_JMPN,
                        OP_CALL, OP_LODS: known = 1'b1;
                        default: known = 1'b0;
                    endcase
                end
                while (known);
                prog_img[$urandom_range(0, len - 1)] = b;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: prog_img[len - 1] = OP_JMP;
                    1: prog_img[len - 1] = OP_ADD_I;
                    2: prog_img[len - 1] = OP_ROT_I;
                    default: prog_img[len - 1] = OP_ROT_CL;
                endcase
            end
        end
    endtask

    initial
    begin
        int         i;
        int         len;
        int         wlen;
        int         n;
        int         random_start;
        logic [7:0] sc;
        bit         broken;
        logic [7:0] demo [0:35];

        nop_codes = '{OP_NOP, OP_CLC, OP_STC, OP_JMPN, OP_CALL, OP_LODS};
        // every opcode at least once; the jump at 32 lands on 35, an unknown code
        demo = '{OP_NOP, OP_CLC, OP_STC, OP_JMPN, OP_CALL, OP_LODS,
                 OP_DEC, 8'hA7, OP_SUB_CL, 8'h5C, OP_ADD_CL, 8'h3E, OP_XOR_CL, 8'hD1,
                 OP_ADD_I, 8'hFF, OP_XOR_I, 8'h80, OP_SUB_I, 8'h01,
                 OP_ROT_I, MODE_ROL, 8'h09, OP_ROT_I, 8'h11, 8'h03,
                 OP_ROT_CL, MODE_ROR, 8'h6B, OP_ROT_CL, MODE_ROL, 8'h2F,
                 OP_JMP, 8'h01, BAD_OP_CODE, BAD_OP_CODE};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole store so that no entry is ever read unwritten
        for (i = 0; i < 256; i++)
        begin
            prog_img[i] = (i < 36) ? demo[i] : OP_NOP;
            push_item(REQ_PROG, i[7:0], prog_img[i], 8'($urandom_range(0, 255)));
        end

        // directed: empty program, full walk, count wrap, errors and stickiness
        write_reg(REG_PROG_LEN, 0);
        write_reg(REG_START_COUNT, 0);
        push_data(8'h00);
        write_reg(REG_PROG_LEN, 35);
        write_reg(REG_START_COUNT, 8'hFF);
        push_data(8'h00);
        push_data(8'hFF);
        push_data(8'h5A);
        write_reg(REG_START_COUNT, 8'h00);
        push_data(8'hA5);
        push_data(8'h3C);
        write_reg(REG_PROG_LEN, 34);       // jump lands past the end
        push_data(8'hC3);
        write_reg(REG_PROG_LEN, 36);       // unknown opcode
        push_data(8'h11);
        write_reg(REG_PROG_LEN, 35);       // error stays set
        push_data(8'h22);
        write_reg(REG_PROG_LEN, 15);       // first code is kept
        push_data(8'h33);
        write_reg(REG_START_COUNT, 8'h80); // new run: immediate past the end
        push_data(8'h44);
        write_reg(REG_START_COUNT, 8'h01);
        write_reg(REG_PROG_LEN, 22);       // rotate amount past the end
        push_data(8'h55);
        write_reg(REG_START_COUNT, 8'h7F);
        write_reg(REG_PROG_LEN, 33);       // jump offset past the end
        push_data(8'h66);
        write_reg(REG_START_COUNT, 8'h02);
        write_reg(REG_PROG_LEN, 7);        // skipped byte may lie past the end
        push_data(8'h77);
        push_item(REQ_PROG, 8'd35, OP_NOP, 8'h00);
        write_reg(REG_PROG_LEN, 511);      // clamped to the store depth
        write_reg(REG_START_COUNT, 8'h40);
        push_data(8'h88);
        push_data(8'h99);
        write_reg(REG_PROG_LEN, 256);
        push_data(8'hE7);

        // random settings, each with a fresh program and a burst of data
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (items_sent - random_start < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 81;
            end
            else if (items_sent - random_start < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: len = 256;
                    1: len = 511;
                    default: len = $urandom_range(41, 255);
                endcase
            end
            else
                len = $urandom_range(0, 40);
            case ($urandom_range(0, 7))
                0: sc = 8'h00;
                1: sc = 8'hFF;
                default: sc = 8'($urandom_range(0, 255));
            endcase
            broken = ($urandom_range(0, 7) == 0);

            write_reg(REG_PROG_LEN, len);
            write_reg(REG_START_COUNT, {24'b0, sc});
            wlen = (len > 256) ? 256 : len;
            compose_program(wlen, broken);
            for (i = 0; i < wlen; i++)
                push_item(REQ_PROG, i[7:0], prog_img[i], 8'($urandom_range(0, 255)));

            n = $urandom_range(4, 30);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_item(REQ_PROG, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                push_data(8'($urandom_range(0, 255)));
            end
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d program writes and %0d data bytes over %0d register writes",
                 prog_writes, data_sent, reg_writes);
        $display("%0d plain bytes checked, %0d with an error status, %0d mismatches",
                 results_seen, flagged_results, mismatches);
        if (mismatches == 0)
            $display("[poly_decryptor_byte_interpreter] OK");
        else
            $display("[poly_decryptor_byte_interpreter] ERROR");
        $finish;
    end

endmodule
